### src/fud_pkg.sv
`default_nettype none

package fud_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_TOP     = 8'h7F;
    localparam logic [7:0] CASE_MASK    = 8'hDF;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last_of_run;
    } t_result;

    // Hex digits wrap modulo 256, so malformed digits still give a defined value.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_TOP) begin
            return (c & CASE_MASK) - CHAR_UPPER_A + 8'd10;
        end
        return c - CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

### src/fud_if.sv
`default_nettype none

interface fud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface fud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_kind, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### src/form_urlencoded_decoder_top.sv
// Channel   Direction  Payload                              Handshake
// i_in      in         in_byte[7:0], end_of_string          valid/ready
// o_out     out        out_byte[7:0], out_kind[1:0],        valid/ready
//                      last_of_run
//
// One input transaction is decoded in the cycle it is accepted and yields up
// to two results, which enter a four-entry result queue on the next edge.
// Input is accepted every cycle while the queue has room for two results, so
// the sustained rate is one byte per cycle when the output drains one result
// per cycle; the single output port limits the rate to one result per cycle.
// Reset is synchronous and active low; it empties the queue and closes the
// open pair. i_in.ready is low while under two queue entries are free.
`default_nettype none

module form_urlencoded_decoder_top
    import fud_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fud_in_if.sink    i_in,
    fud_out_if.source o_out
);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_HIGH,
        ESC_LOW
    } t_esc;

    t_esc              r_esc;
    t_esc              n_esc;
    logic              r_value;
    logic              n_value;
    logic [7:0]        r_high;
    logic [7:0]        n_high;

    t_result           r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              in_fire;
    logic              out_fire;
    logic [7:0]        char_in;
    logic              have_byte;
    logic [7:0]        dec_byte;
    logic              emit_byte;
    t_result           res0;
    t_result           res1;
    logic [1:0]        num_res;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count <= CNT_W'(QUEUE_DEPTH - 2));

    assign o_out.valid       = (r_count != '0);
    assign o_out.out_byte    = r_queue[r_rd_ptr].out_byte;
    assign o_out.out_kind    = r_queue[r_rd_ptr].out_kind;
    assign o_out.last_of_run = r_queue[r_rd_ptr].last_of_run;

    always_comb begin
        char_in   = (i_in.in_byte == CHAR_PLUS) ? CHAR_SPACE : i_in.in_byte;
        n_esc     = r_esc;
        n_value   = r_value;
        n_high    = r_high;
        have_byte = 1'b0;
        dec_byte  = char_in;
        emit_byte = 1'b0;
        res0      = '{out_byte: 8'd0, out_kind: KIND_END, last_of_run: 1'b1};
        res1      = '{out_byte: 8'd0, out_kind: KIND_END, last_of_run: 1'b1};
        num_res   = 2'd0;

        if (i_in.in_byte == CHAR_AMP) begin
            num_res = 2'd1;
            n_esc   = ESC_IDLE;
            n_value = 1'b0;
            n_high  = 8'd0;
        end else begin
            unique case (r_esc)
                ESC_HIGH: begin
                    n_high = digit_value(char_in);
                    n_esc  = ESC_LOW;
                end
                ESC_LOW: begin
                    dec_byte  = {r_high[3:0], 4'd0} + digit_value(char_in);
                    have_byte = 1'b1;
                    n_esc     = ESC_IDLE;
                end
                default: begin
                    if (char_in == CHAR_PERCENT) begin
                        n_esc = ESC_HIGH;
                    end else begin
                        n_esc     = ESC_IDLE;
                        have_byte = 1'b1;
                    end
                end
            endcase

            if (have_byte) begin
                if (dec_byte == CHAR_EQUALS && !r_value) begin
                    n_value = 1'b1;
                end else begin
                    emit_byte = 1'b1;
                end
            end

            if (emit_byte) begin
                res0.out_byte    = dec_byte;
                res0.out_kind    = r_value ? KIND_VALUE : KIND_NAME;
                res0.last_of_run = !i_in.end_of_string;
            end

            num_res = {1'b0, emit_byte} + {1'b0, i_in.end_of_string};

            if (i_in.end_of_string) begin
                n_esc   = ESC_IDLE;
                n_value = 1'b0;
                n_high  = 8'd0;
            end
        end

        n_count = r_count + (in_fire ? CNT_W'(num_res) : CNT_W'(0))
                  - (out_fire ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= ESC_IDLE;
            r_value  <= 1'b0;
            r_high   <= 8'd0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_esc    <= n_esc;
                r_value  <= n_value;
                r_high   <= n_high;
                r_wr_ptr <= r_wr_ptr + PTR_W'(num_res);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && num_res != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
            if (num_res == 2'd2) begin
                r_queue[r_wr_ptr + PTR_W'(1)] <= res1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_amp_closes_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.in_byte == CHAR_AMP |=> r_esc == ESC_IDLE && !r_value)
        else $error("An ampersand did not close the open pair.");

    a_eos_closes_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.end_of_string |=> r_esc == ESC_IDLE && !r_value && r_high == 8'd0)
        else $error("End of string did not close the open pair.");

    a_end_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_kind == KIND_END |-> o_out.out_byte == 8'd0)
        else $error("A pair-end result carries a nonzero byte.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire && out_fire |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("Queue occupancy did not drop after a lone output transaction.");

endmodule

`default_nettype wire
